[src/fisheye_undistort_map_defines.svh]
// Assertion macros shared by the fisheye undistort map RTL.
`ifndef FISHEYE_UNDISTORT_MAP_DEFINES_SVH
`define FISHEYE_UNDISTORT_MAP_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define FUM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define FUM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/fum_pkg.sv]
// Types, register codes and constant tables for the fisheye undistort map.
package fum_pkg;

  localparam int PIX_W      = 12;
  localparam int CFG_W      = 64;
  localparam int SQRT_STEPS = 31;  // root bits of a 61-bit radicand
  localparam int DIV_STEPS  = 31;  // quotient bits of the direction ratio

  typedef struct packed {
    logic [PIX_W-1:0] pixel_col;
    logic [PIX_W-1:0] pixel_row;
  } pixel_t;

  typedef struct packed {
    logic signed [31:0] src_u;
    logic signed [31:0] src_v;
    logic signed [15:0] int_u;
    logic signed [15:0] int_v;
    logic [9:0]         frac_index;
    logic               behind_camera;
  } result_t;

  typedef enum logic [2:0] {
    REG_RAY_A  = 3'd0,
    REG_RAY_B  = 3'd1,
    REG_RAY_C  = 3'd2,
    REG_RAY_D  = 3'd3,
    REG_RAY_E  = 3'd4,
    REG_FOCAL  = 3'd5,
    REG_CENTRE = 3'd6,
    REG_DIST   = 3'd7
  } cfg_reg_e;

  // Ray classification that travels with each pixel
  typedef struct packed {
    logic behind;
    logic x_pos;
    logic x_neg;
    logic y_pos;
    logic y_neg;
    logic r_zero;
  } ray_flags_t;

  // Scaled ray magnitudes carried alongside the root extraction
  typedef struct packed {
    logic [29:0] ax;
    logic [29:0] ay;
    logic [29:0] aw;
    ray_flags_t  fl;
  } ray_carry_t;

  // Rounded arctangent of 2^-i in Q2.30
  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    logic [29:0] res;
    unique case (i)
      5'd0:  res = 30'd843314857;
      5'd1:  res = 30'd497837829;
      5'd2:  res = 30'd263043837;
      5'd3:  res = 30'd133525159;
      5'd4:  res = 30'd67021687;
      5'd5:  res = 30'd33543516;
      5'd6:  res = 30'd16775851;
      5'd7:  res = 30'd8388437;
      5'd8:  res = 30'd4194283;
      5'd9:  res = 30'd2097149;
      5'd10: res = 30'd1048576;
      5'd11: res = 30'd524288;
      5'd12: res = 30'd262144;
      5'd13: res = 30'd131072;
      5'd14: res = 30'd65536;
      5'd15: res = 30'd32768;
      5'd16: res = 30'd16384;
      5'd17: res = 30'd8192;
      5'd18: res = 30'd4096;
      5'd19: res = 30'd2048;
      5'd20: res = 30'd1024;
      5'd21: res = 30'd512;
      5'd22: res = 30'd256;
      5'd23: res = 30'd128;
      5'd24: res = 30'd64;
      5'd25: res = 30'd32;
      5'd26: res = 30'd16;
      5'd27: res = 30'd8;
      5'd28: res = 30'd4;
      5'd29: res = 30'd2;
      5'd30: res = 30'd1;
      5'd31: res = 30'd0;
    endcase
    return res;
  endfunction

endpackage

[src/fisheye_undistort_map.sv]
// Fisheye undistort map: pipelined output-pixel to source-coordinate mapper.
//
// One pixel may be started in every clock cycle; busy is high only during
// reset. Each start gives exactly one result, shown with done for one cycle.
// The pipeline depth is set by the square root and the direction divide
// (one result bit per stage) and by the CORDIC (one rotation per stage).
// The receiver cannot stall the result. Registers are written through
// cfg_we / cfg_index / cfg_data and must only change while no pixel is in
// flight.
`include "fisheye_undistort_map_defines.svh"

module fisheye_undistort_map import fum_pkg::*; #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 5,
  parameter int ATAN_STEPS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  pixel_t           pixel,
  output logic             done,
  output result_t          result,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int DS_STEPS = (ATAN_STEPS > DIV_STEPS) ? ATAN_STEPS : DIV_STEPS;
  localparam int N_STG    = 6 + SQRT_STEPS + DS_STEPS + 12;
  localparam logic [PIX_W-1:0] CMASK = PIX_W'((64'd1 << COORD_BITS) - 64'd1);
  localparam int RND_SH   = 15 - FRAC_BITS;
  localparam int IU_SH    = 16 - FRAC_BITS;
  localparam int FIW      = (2 * FRAC_BITS > 10) ? 2 * FRAC_BITS : 10;
  localparam logic signed [33:0] RND      = 34'(64'd1 << RND_SH);
  localparam logic signed [49:0] ONE_Q38  = 50'(64'd1 << 38);
  localparam logic signed [31:0] S32_MAX  = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN  = 32'sh8000_0000;

  // ---------------------------------------------------------------- registers
  logic [63:0] ray_matrix_a, ray_matrix_b, ray_matrix_c, ray_matrix_d;
  logic [31:0] ray_matrix_e;
  logic [63:0] focal_pair, centre_pair, lens_coeffs;

  always_ff @(posedge clk) begin
    if (rst) begin
      ray_matrix_a <= '0;
      ray_matrix_b <= '0;
      ray_matrix_c <= '0;
      ray_matrix_d <= '0;
      ray_matrix_e <= '0;
      focal_pair   <= '0;
      centre_pair  <= '0;
      lens_coeffs  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_e'(cfg_index))
        REG_RAY_A:  ray_matrix_a <= cfg_data;
        REG_RAY_B:  ray_matrix_b <= cfg_data;
        REG_RAY_C:  ray_matrix_c <= cfg_data;
        REG_RAY_D:  ray_matrix_d <= cfg_data;
        REG_RAY_E:  ray_matrix_e <= cfg_data[31:0];
        REG_FOCAL:  focal_pair   <= cfg_data;
        REG_CENTRE: centre_pair  <= cfg_data;
        REG_DIST:   lens_coeffs  <= cfg_data;
      endcase
    end
  end

  logic signed [31:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
  logic [31:0] fx, fy, cx, cy;
  logic signed [15:0] k0, k1, k2, k3;

  assign m00 = $signed(ray_matrix_a[31:0]);
  assign m01 = $signed(ray_matrix_a[63:32]);
  assign m02 = $signed(ray_matrix_b[31:0]);
  assign m10 = $signed(ray_matrix_b[63:32]);
  assign m11 = $signed(ray_matrix_c[31:0]);
  assign m12 = $signed(ray_matrix_c[63:32]);
  assign m20 = $signed(ray_matrix_d[31:0]);
  assign m21 = $signed(ray_matrix_d[63:32]);
  assign m22 = $signed(ray_matrix_e);
  assign fx  = focal_pair[31:0];
  assign fy  = focal_pair[63:32];
  assign cx  = centre_pair[31:0];
  assign cy  = centre_pair[63:32];
  assign k0  = $signed(lens_coeffs[15:0]);
  assign k1  = $signed(lens_coeffs[31:16]);
  assign k2  = $signed(lens_coeffs[47:32]);
  assign k3  = $signed(lens_coeffs[63:48]);

  // ------------------------------------------------------------ handshake
  logic acc;
  logic [N_STG-1:0] vld;

  assign busy = rst;
  assign acc  = start && !busy;
  assign done = vld[N_STG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[N_STG-2:0], acc};
    end
  end

  // ---------------------------------------------------------- helpers
  function automatic logic signed [32:0] tz33(input logic signed [32:0] v, input int n);
    logic signed [32:0] m;
    m = v[32] ? -v : v;
    m = m >>> n;
    return v[32] ? -m : m;
  endfunction

  function automatic logic [3:0] bitlen15(input logic [14:0] v);
    logic [3:0] res;
    res = '0;
    for (int i = 0; i < 15; i++) begin
      if (v[i]) res = 4'(i + 1);
    end
    return res;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [42:0] v);
    if (v > 43'(S32_MAX)) return S32_MAX;
    if (v < 43'(S32_MIN)) return S32_MIN;
    return v[31:0];
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [33:0] v);
    if (v > 34'sd32767) return 16'sh7FFF;
    if (v < -34'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  // ---------------------------------------------------------- front end
  logic [PIX_W-1:0] col_m, row_m;
  logic signed [PIX_W:0] col_s, row_s;
  logic signed [44:0] s1_px0, s1_px1, s1_py0, s1_py1, s1_pw0, s1_pw1;
  logic signed [45:0] s2_x, s2_y, s2_w;
  logic [44:0] ax_c, ay_c, mxy_c;
  logic [44:0] s3_ax, s3_ay, s3_aw, s3_mx;
  ray_flags_t s3_fl, fl_c;
  logic [3:0] sh_c;
  ray_carry_t s4_car, s5_car, s6_car;
  logic [59:0] s5_sqx, s5_sqy;
  logic [60:0] s6_n;

  assign col_m = pixel.pixel_col & CMASK;
  assign row_m = pixel.pixel_row & CMASK;
  assign col_s = $signed({1'b0, col_m});
  assign row_s = $signed({1'b0, row_m});

  // Magnitudes, classification and the common scale
  always_comb begin
    ax_c  = 45'(s2_x[45] ? -s2_x : s2_x);
    ay_c  = 45'(s2_y[45] ? -s2_y : s2_y);
    mxy_c = (ax_c > ay_c) ? ax_c : ay_c;
    fl_c.behind = s2_w[45] || (s2_w == '0);
    fl_c.x_pos  = !s2_x[45] && (s2_x != '0);
    fl_c.x_neg  = s2_x[45];
    fl_c.y_pos  = !s2_y[45] && (s2_y != '0);
    fl_c.y_neg  = s2_y[45];
    fl_c.r_zero = 1'b0;
    sh_c = bitlen15(s3_mx[44:30]);
  end

  always_ff @(posedge clk) begin
    // products of the pixel with the matrix
    s1_px0 <= 45'(col_s) * 45'(m00);
    s1_px1 <= 45'(row_s) * 45'(m01);
    s1_py0 <= 45'(col_s) * 45'(m10);
    s1_py1 <= 45'(row_s) * 45'(m11);
    s1_pw0 <= 45'(col_s) * 45'(m20);
    s1_pw1 <= 45'(row_s) * 45'(m21);
    // ray sums
    s2_x <= 46'(s1_px0) + 46'(s1_px1) + 46'(m02);
    s2_y <= 46'(s1_py0) + 46'(s1_py1) + 46'(m12);
    s2_w <= 46'(s1_pw0) + 46'(s1_pw1) + 46'(m22);
    // magnitudes and their maximum
    s3_ax <= ax_c;
    s3_ay <= ay_c;
    s3_aw <= s2_w[44:0];
    s3_mx <= (mxy_c > s2_w[44:0]) ? mxy_c : s2_w[44:0];
    s3_fl <= fl_c;
    // scale below 2^30
    s4_car.ax <= 30'(s3_ax >> sh_c);
    s4_car.ay <= 30'(s3_ay >> sh_c);
    s4_car.aw <= 30'(s3_aw >> sh_c);
    s4_car.fl <= s3_fl;
    // squares
    s5_sqx <= 60'(s4_car.ax) * 60'(s4_car.ax);
    s5_sqy <= 60'(s4_car.ay) * 60'(s4_car.ay);
    s5_car <= s4_car;
    // radicand
    s6_n   <= 61'(s5_sqx) + 61'(s5_sqy);
    s6_car <= s5_car;
  end

  // ---------------------------------------------------------- square root
  logic [61:0] sq_rem  [SQRT_STEPS];
  logic [30:0] sq_root [SQRT_STEPS];
  ray_carry_t  sq_car  [SQRT_STEPS];

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    localparam int K = SQRT_STEPS - 1 - j;
    logic [61:0] rem_in, delta;
    logic [30:0] root_in;
    ray_carry_t  car_in;

    if (j == 0) begin : g_first
      assign rem_in  = 62'(s6_n);
      assign root_in = '0;
      assign car_in  = s6_car;
    end else begin : g_next
      assign rem_in  = sq_rem[j-1];
      assign root_in = sq_root[j-1];
      assign car_in  = sq_car[j-1];
    end

    // one root bit: (root + 2^K)^2 - root^2
    assign delta = (62'(root_in) << (K + 1)) | (62'(1) << (2 * K));

    always_ff @(posedge clk) begin
      if (delta <= rem_in) begin
        sq_rem[j]  <= rem_in - delta;
        sq_root[j] <= root_in | (31'(1) << K);
      end else begin
        sq_rem[j]  <= rem_in;
        sq_root[j] <= root_in;
      end
      sq_car[j] <= car_in;
    end
  end

  // ------------------------------------------- CORDIC and direction divide
  logic signed [32:0] ds_a  [DS_STEPS];
  logic signed [32:0] ds_b  [DS_STEPS];
  logic signed [32:0] ds_z  [DS_STEPS];
  logic [61:0]        ds_rx [DS_STEPS];
  logic [61:0]        ds_ry [DS_STEPS];
  logic [30:0]        ds_qx [DS_STEPS];
  logic [30:0]        ds_qy [DS_STEPS];
  logic [30:0]        ds_r  [DS_STEPS];
  ray_flags_t         ds_fl [DS_STEPS];

  for (genvar j = 0; j < DS_STEPS; j++) begin : g_ds
    localparam int KD = (j < DIV_STEPS) ? (DIV_STEPS - 1 - j) : 0;
    logic signed [32:0] a_in, b_in, z_in, a_n, b_n, z_n, da, db;
    logic [61:0] rx_in, ry_in, rx_n, ry_n, dv;
    logic [30:0] qx_in, qy_in, qx_n, qy_n, r_in;
    ray_flags_t  fl_in;

    if (j == 0) begin : g_first
      assign r_in  = sq_root[SQRT_STEPS-1];
      assign a_in  = $signed(33'(sq_car[SQRT_STEPS-1].aw));
      assign b_in  = $signed(33'(sq_root[SQRT_STEPS-1]));
      assign z_in  = '0;
      assign rx_in = 62'(sq_car[SQRT_STEPS-1].ax) << 30;
      assign ry_in = 62'(sq_car[SQRT_STEPS-1].ay) << 30;
      assign qx_in = '0;
      assign qy_in = '0;
      assign fl_in = sq_car[SQRT_STEPS-1].fl;
    end else begin : g_next
      assign r_in  = ds_r[j-1];
      assign a_in  = ds_a[j-1];
      assign b_in  = ds_b[j-1];
      assign z_in  = ds_z[j-1];
      assign rx_in = ds_rx[j-1];
      assign ry_in = ds_ry[j-1];
      assign qx_in = ds_qx[j-1];
      assign qy_in = ds_qy[j-1];
      assign fl_in = ds_fl[j-1];
    end

    always_comb begin
      a_n  = a_in;
      b_n  = b_in;
      z_n  = z_in;
      rx_n = rx_in;
      ry_n = ry_in;
      qx_n = qx_in;
      qy_n = qy_in;
      da   = tz33(b_in, j);
      db   = tz33(a_in, j);
      dv   = 62'(r_in) << KD;
      // vectoring rotation toward b = 0
      if (j < ATAN_STEPS) begin
        if (b_in > 33'sd0) begin
          a_n = a_in + da;
          b_n = b_in - db;
          z_n = z_in + $signed(33'(atan_q30(5'(j))));
        end else begin
          a_n = a_in - da;
          b_n = b_in + db;
          z_n = z_in - $signed(33'(atan_q30(5'(j))));
        end
      end
      // one quotient bit of |X| / R and |Y| / R in Q.30
      if (j < DIV_STEPS) begin
        if (dv <= rx_in) begin
          rx_n = rx_in - dv;
          qx_n = qx_in | (31'(1) << KD);
        end
        if (dv <= ry_in) begin
          ry_n = ry_in - dv;
          qy_n = qy_in | (31'(1) << KD);
        end
      end
    end

    always_ff @(posedge clk) begin
      ds_a[j]  <= a_n;
      ds_b[j]  <= b_n;
      ds_z[j]  <= z_n;
      ds_rx[j] <= rx_n;
      ds_ry[j] <= ry_n;
      ds_qx[j] <= qx_n;
      ds_qy[j] <= qy_n;
      ds_r[j]  <= r_in;
      ds_fl[j] <= fl_in;
    end
  end

  // ---------------------------------------------------------- back end
  logic [30:0] zc_c;
  logic [24:0] t_c;
  ray_flags_t  fl1_c;
  logic [30:0] bk_zc   [1:6];
  ray_flags_t  bk_fl   [1:11];
  logic [30:0] bk_dirx [1:8];
  logic [30:0] bk_diry [1:8];
  logic [25:0] b1_t2, b2_t2, b3_t2;
  logic [27:0] b2_t4, b3_t4;
  logic [29:0] b3_t6;
  logic [30:0] b3_t8;
  logic signed [47:0] b4_k2, b4_k4, b4_k6, b4_k8;
  logic signed [49:0] b5_s01, b5_s23, sum_c;
  logic signed [35:0] b6_poly;
  logic signed [17:0] ph_c;
  logic [48:0] b7_zl;
  logic signed [49:0] b7_zh;
  logic signed [67:0] prod_c;
  logic b8_neg, b9_neg, b10_neg;
  logic [32:0] b8_mag;
  logic [32:0] b9_mx, b9_my;
  logic [40:0] b10_px, b10_py;
  logic signed [42:0] valx_c, valy_c;
  logic signed [31:0] b11_u, b11_v;
  logic signed [33:0] iu_c, iv_c;
  logic [FIW-1:0] fiw_c;

  always_comb begin
    zc_c  = ds_z[DS_STEPS-1][32] ? '0 : ds_z[DS_STEPS-1][30:0];
    t_c   = 25'(zc_c >> 6);
    fl1_c = ds_fl[DS_STEPS-1];
    fl1_c.r_zero = (ds_r[DS_STEPS-1] == '0);
    sum_c  = b5_s01 + b5_s23;
    ph_c   = $signed(b6_poly[35:18]);
    prod_c = ($signed(68'(b7_zh)) <<< 18) + $signed(68'(b7_zl));
    valx_c = $signed(43'(cx)) + ((bk_fl[10].x_neg ^ b10_neg) ? -$signed(43'(b10_px))
                                                              : $signed(43'(b10_px)));
    valy_c = $signed(43'(cy)) + ((bk_fl[10].y_neg ^ b10_neg) ? -$signed(43'(b10_py))
                                                              : $signed(43'(b10_py)));
    // table form: coordinate in 2^-FRAC_BITS steps, rounded half up
    iu_c  = (34'(b11_u) + RND) >>> IU_SH;
    iv_c  = (34'(b11_v) + RND) >>> IU_SH;
    fiw_c = FIW'({iv_c[FRAC_BITS-1:0], iu_c[FRAC_BITS-1:0]});
  end

  always_ff @(posedge clk) begin
    // side data shift lines
    bk_zc[1]   <= zc_c;
    bk_fl[1]   <= fl1_c;
    bk_dirx[1] <= ds_qx[DS_STEPS-1];
    bk_diry[1] <= ds_qy[DS_STEPS-1];
    for (int i = 2; i <= 6; i++) bk_zc[i] <= bk_zc[i-1];
    for (int i = 2; i <= 11; i++) bk_fl[i] <= bk_fl[i-1];
    for (int i = 2; i <= 8; i++) begin
      bk_dirx[i] <= bk_dirx[i-1];
      bk_diry[i] <= bk_diry[i-1];
    end
    // powers of theta in Q.24
    b1_t2 <= 26'((50'(t_c) * 50'(t_c)) >> 24);
    b2_t4 <= 28'((52'(b1_t2) * 52'(b1_t2)) >> 24);
    b2_t2 <= b1_t2;
    b3_t6 <= 30'((54'(b2_t4) * 54'(b2_t2)) >> 24);
    b3_t8 <= 31'((56'(b2_t4) * 56'(b2_t4)) >> 24);
    b3_t2 <= b2_t2;
    b3_t4 <= b2_t4;
    // coefficient terms in Q.38
    b4_k2 <= 48'(k0) * $signed(48'(b3_t2));
    b4_k4 <= 48'(k1) * $signed(48'(b3_t4));
    b4_k6 <= 48'(k2) * $signed(48'(b3_t6));
    b4_k8 <= 48'(k3) * $signed(48'(b3_t8));
    b5_s01 <= 50'(b4_k2) + 50'(b4_k4) + ONE_Q38;
    b5_s23 <= 50'(b4_k6) + 50'(b4_k8);
    b6_poly <= 36'(sum_c[49] ? -((-sum_c) >>> 14) : (sum_c >>> 14));
    // theta * poly as two partial products
    b7_zl <= 49'(bk_zc[6]) * 49'(b6_poly[17:0]);
    b7_zh <= $signed(50'(bk_zc[6])) * 50'(ph_c);
    // theta_d in Q.24, sign and magnitude
    b8_neg <= prod_c[67];
    b8_mag <= 33'((prod_c[67] ? -prod_c : prod_c) >> 30);
    // direction and focal scaling
    b9_mx  <= 33'((64'(b8_mag) * 64'(bk_dirx[8])) >> 30);
    b9_my  <= 33'((64'(b8_mag) * 64'(bk_diry[8])) >> 30);
    b9_neg <= b8_neg;
    b10_px  <= 41'((65'(b9_mx) * 65'(fx)) >> 24);
    b10_py  <= 41'((65'(b9_my) * 65'(fy)) >> 24);
    b10_neg <= b9_neg;
    // centre and the special cases
    if (bk_fl[10].behind) begin
      b11_u <= bk_fl[10].x_pos ? S32_MIN : S32_MAX;
      b11_v <= bk_fl[10].y_pos ? S32_MIN : S32_MAX;
    end else if (bk_fl[10].r_zero) begin
      b11_u <= sat32($signed(43'(cx)));
      b11_v <= sat32($signed(43'(cy)));
    end else begin
      b11_u <= sat32(valx_c);
      b11_v <= sat32(valy_c);
    end
    // output register
    result.src_u         <= b11_u;
    result.src_v         <= b11_v;
    result.int_u         <= sat16(iu_c >>> FRAC_BITS);
    result.int_v         <= sat16(iv_c >>> FRAC_BITS);
    result.frac_index    <= fiw_c[9:0];
    result.behind_camera <= bk_fl[11].behind;
  end

  // ---------------------------------------------------------- assertions
  `FUM_ASSERT_NOW(a_latency, clk, rst, done, $past(acc, N_STG),
    "result without a start at the pipeline latency")
  `FUM_ASSERT_NOW(a_behind_u, clk, rst, done && result.behind_camera,
    (result.src_u == S32_MIN) || (result.src_u == S32_MAX),
    "behind-camera u not saturated")
  `FUM_ASSERT_NOW(a_behind_v, clk, rst, done && result.behind_camera,
    (result.src_v == S32_MIN) || (result.src_v == S32_MAX),
    "behind-camera v not saturated")
  `FUM_ASSERT_NEXT(a_flag_out, clk, rst, vld[N_STG-2] && bk_fl[11].behind,
    done && result.behind_camera, "behind flag lost at the output")

endmodule

[sim/tb_fisheye_undistort_map.sv]
// Testbench for the fisheye undistort map: directed and random pixels checked against a predictor.
`timescale 1ns / 1ps

module tb_fisheye_undistort_map;
  import fum_pkg::*;

  localparam int FRAC_B  = 5;
  localparam int STEPS   = 16;
  localparam int LATENCY = 80;

  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  pixel_t           pixel;
  logic             done;
  result_t          result;
  logic             cfg_we;
  logic [2:0]       cfg_index;
  logic [CFG_W-1:0] cfg_data;

  // Shadow of the configuration registers
  bit [63:0] cfg_shadow [8];
  // Expected source coordinates, oldest first
  result_t   coord_q [$];
  int        err_count;
  int        burst_left;

  // Arctangent of 2^-i in Q2.30, rounded
  localparam longint ATAN_TAB [16] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
    65536, 32768};

  fisheye_undistort_map DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .pixel(pixel),
    .done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  initial begin
    #5ms;
    $display("*** FAILED ***");
    $finish;
  end

  // ---------------------------------------------------------------- predictor
  function automatic longint mat_entry(int i);
    bit [63:0] w;
    w = cfg_shadow[i >> 1];
    if (i & 1) return longint'(signed'(w[63:32]));
    return longint'(signed'(w[31:0]));
  endfunction

  // Shift right, truncating toward zero
  function automatic longint shr_tz(longint v, int n);
    bit [63:0] m;
    if (v < 0) begin
      m = -v;
      return -longint'(m >> n);
    end
    return v >>> n;
  endfunction

  function automatic bit [63:0] int_sqrt(bit [63:0] n);
    bit [63:0] res, bt;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > n) bt >>= 2;
    while (bt != 0) begin
      if (n >= res + bt) begin
        n -= res + bt;
        res = (res >> 1) + bt;
      end else begin
        res >>= 1;
      end
      bt >>= 2;
    end
    return res;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // c + f * theta_d * (a / R), Q16.16
  function automatic longint axis_pos(bit [63:0] amag, bit neg, bit [63:0] r, longint td,
                                      bit [63:0] f, bit [63:0] c);
    bit [63:0] dir, m, p, tmag;
    bit        n;
    tmag = (td < 0) ? -td : td;
    dir  = (amag << 30) / r;
    m    = (tmag * dir) >> 30;
    p    = (m * f) >> 24;
    n    = neg ^ (td < 0);
    return clamp32(longint'(c) + (n ? -longint'(p) : longint'(p)));
  endfunction

  // Table form: integer part and fraction of one axis
  function automatic void split_coord(longint q16, output bit [15:0] ip_o,
                                      output bit [FRAC_B-1:0] fr_o);
    longint iu, ip;
    iu = (q16 + (64'sd1 << (15 - FRAC_B))) >>> (16 - FRAC_B);
    ip = iu >>> FRAC_B;
    if (ip > 32767) ip = 32767;
    if (ip < -32768) ip = -32768;
    ip_o = ip[15:0];
    fr_o = iu[FRAC_B-1:0];
  endfunction

  function automatic result_t map_pixel(pixel_t p);
    result_t            res;
    longint             col, row, X, Y, W, u, v, a, b, z, da, db;
    longint             t, t2, t4, t6, t8, poly, td;
    bit [63:0]          ax, ay, aw, mx, r, fx, fy, cx, cy;
    bit [FRAC_B-1:0]    fu, fv;
    int                 s;
    col = p.pixel_col;
    row = p.pixel_row;
    X = col * mat_entry(0) + row * mat_entry(1) + mat_entry(2);
    Y = col * mat_entry(3) + row * mat_entry(4) + mat_entry(5);
    W = col * mat_entry(6) + row * mat_entry(7) + mat_entry(8);
    fx = cfg_shadow[REG_FOCAL][31:0];
    fy = cfg_shadow[REG_FOCAL][63:32];
    cx = cfg_shadow[REG_CENTRE][31:0];
    cy = cfg_shadow[REG_CENTRE][63:32];
    if (W <= 0) begin
      // behind the camera: saturate opposite to the ray sign
      u = (X > 0) ? -64'sd2147483648 : 64'sd2147483647;
      v = (Y > 0) ? -64'sd2147483648 : 64'sd2147483647;
    end else begin
      ax = (X < 0) ? -X : X;
      ay = (Y < 0) ? -Y : Y;
      aw = W;
      mx = ax;
      if (ay > mx) mx = ay;
      if (aw > mx) mx = aw;
      s = 0;
      while ((mx >> s) >= (64'd1 << 30)) s++;
      ax >>= s;
      ay >>= s;
      aw >>= s;
      r = int_sqrt(ax * ax + ay * ay);
      if (r == 0) begin
        u = clamp32(longint'(cx));
        v = clamp32(longint'(cy));
      end else begin
        // vectoring CORDIC for atan(R/W)
        a = aw;
        b = r;
        z = 0;
        for (int i = 0; i < STEPS; i++) begin
          da = shr_tz(b, i);
          db = shr_tz(a, i);
          if (b > 0) begin
            a += da; b -= db; z += ATAN_TAB[i];
          end else begin
            a -= da; b += db; z -= ATAN_TAB[i];
          end
        end
        if (z < 0) z = 0;
        t  = z >>> 6;
        t2 = (t * t) >>> 24;
        t4 = (t2 * t2) >>> 24;
        t6 = (t4 * t2) >>> 24;
        t8 = (t4 * t4) >>> 24;
        poly = (64'sd1 << 38)
             + longint'(signed'(cfg_shadow[REG_DIST][15:0])) * t2
             + longint'(signed'(cfg_shadow[REG_DIST][31:16])) * t4
             + longint'(signed'(cfg_shadow[REG_DIST][47:32])) * t6
             + longint'(signed'(cfg_shadow[REG_DIST][63:48])) * t8;
        poly = shr_tz(poly, 14);
        td = shr_tz(z * poly, 24);
        td = shr_tz(td, 6);
        u = axis_pos(ax, X < 0, r, td, fx, cx);
        v = axis_pos(ay, Y < 0, r, td, fy, cy);
      end
    end
    res.src_u = u[31:0];
    res.src_v = v[31:0];
    split_coord(u, res.int_u, fu);
    split_coord(v, res.int_v, fv);
    res.frac_index = {fv, fu};
    res.behind_camera = (W <= 0);
    return res;
  endfunction

  // ---------------------------------------------------------------- checker
  always @(posedge clk) begin
    result_t exp_r;
    if (!rst && done) begin
      if (coord_q.size() == 0) begin
        $error("result with no pending pixel");
        err_count++;
      end else begin
        exp_r = coord_q.pop_front();
        if (result.src_u !== exp_r.src_u) begin
          $error("src_u exp %h got %h", exp_r.src_u, result.src_u); err_count++;
        end
        if (result.src_v !== exp_r.src_v) begin
          $error("src_v exp %h got %h", exp_r.src_v, result.src_v); err_count++;
        end
        if (result.int_u !== exp_r.int_u) begin
          $error("int_u exp %h got %h", exp_r.int_u, result.int_u); err_count++;
        end
        if (result.int_v !== exp_r.int_v) begin
          $error("int_v exp %h got %h", exp_r.int_v, result.int_v); err_count++;
        end
        if (result.frac_index !== exp_r.frac_index) begin
          $error("frac_index exp %h got %h", exp_r.frac_index, result.frac_index);
          err_count++;
        end
        if (result.behind_camera !== exp_r.behind_camera) begin
          $error("behind_camera exp %b got %b", exp_r.behind_camera, result.behind_camera);
          err_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- drivers
  // One pixel transfer, with bursts and random gaps between them
  task automatic send_pixel(bit [11:0] col, bit [11:0] row);
    pixel_t p;
    p.pixel_col = col;
    p.pixel_row = row;
    if (burst_left <= 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 150)
                                                : $urandom_range(1, 20);
    end
    start <= 1'b1;
    pixel <= p;
    do @(posedge clk); while (busy);
    coord_q.push_back(map_pixel(p));
    burst_left--;
  endtask

  // Let every pixel in flight come out
  task automatic drain;
    start <= 1'b0;
    while (coord_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  // One register write; a leading edge keeps writes in a row apart
  task automatic write_reg(cfg_reg_e idx, bit [63:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_shadow[idx] = (idx == REG_RAY_E) ? {32'd0, val[31:0]} : val;
  endtask

  // Inverse pinhole camera: x = (col - cx) / f, identity rotation
  task automatic set_pinhole(int f, int cx, int cy, bit [63:0] k);
    longint inv, ox, oy;
    inv = (64'sd1 <<< 28) / f;
    ox  = -((longint'(cx) <<< 28) / f);
    oy  = -((longint'(cy) <<< 28) / f);
    write_reg(REG_RAY_A, {32'd0, inv[31:0]});
    write_reg(REG_RAY_B, {32'd0, ox[31:0]});
    write_reg(REG_RAY_C, {oy[31:0], inv[31:0]});
    write_reg(REG_RAY_D, 64'd0);
    write_reg(REG_RAY_E, 64'h1000_0000);
    write_reg(REG_FOCAL, {16'(f), 16'd0, 16'(f), 16'd0});
    write_reg(REG_CENTRE, {16'(cy), 16'd0, 16'(cx), 16'd0});
    write_reg(REG_DIST, k);
  endtask

  function automatic bit [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Small signed Q2.14 coefficients of either sign
  function automatic bit [63:0] rand_coeffs();
    bit [63:0] k;
    for (int i = 0; i < 4; i++) k[i*16 +: 16] = 16'($signed($urandom_range(0, 4000)) - 2000);
    return k;
  endfunction

  // ---------------------------------------------------------------- tests
  // Registers at reset: W is zero, every pixel is behind the camera
  task automatic test_reset_state;
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd4095, 12'd0);
    drain();
  endtask

  // Pinhole camera: corners, centre and lens distortion
  task automatic test_pinhole;
    set_pinhole(500, 960, 540, {16'sd100, -16'sd200, 16'sd300, -16'sd1000});
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd0);
    send_pixel(12'd0, 12'd4095);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd960, 12'd540);   // ray on the optical axis
    send_pixel(12'd961, 12'd540);
    send_pixel(12'd960, 12'd2000);
    send_pixel(12'd2730, 12'd1365);
    drain();
  endtask

  // Zero ray direction, then extreme focal and centre so everything saturates
  task automatic test_axis_and_saturation;
    write_reg(REG_RAY_A, 64'd0);
    write_reg(REG_RAY_B, 64'd0);
    write_reg(REG_RAY_C, 64'd0);
    write_reg(REG_RAY_D, 64'd0);
    write_reg(REG_RAY_E, 64'hFFFF_FFFF_7FFF_FFFF);
    write_reg(REG_FOCAL, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_CENTRE, 64'hFFFF_FFFF_8000_0000);
    write_reg(REG_DIST, 64'h7FFF_7FFF_7FFF_7FFF);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    drain();
    set_pinhole(1, 0, 0, 64'h8000_8000_8000_8000);
    write_reg(REG_FOCAL, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_CENTRE, 64'hFFFF_FFFF_FFFF_FFFF);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd1, 12'd0);
    send_pixel(12'd0, 12'd1);
    drain();
    // negative W with rays of every sign
    write_reg(REG_RAY_A, 64'h8000_0000_7FFF_FFFF);
    write_reg(REG_RAY_B, 64'h8000_0000_0000_0000);
    write_reg(REG_RAY_C, 64'h0000_0000_7FFF_FFFF);
    write_reg(REG_RAY_D, 64'hF000_0000_F000_0000);
    write_reg(REG_RAY_E, 64'h8000_0000);
    send_pixel(12'd4095, 12'd0);
    send_pixel(12'd0, 12'd4095);
    send_pixel(12'd100, 12'd3000);
    drain();
  endtask

  // Random pixels over several random settings
  task automatic test_random;
    for (int ph = 0; ph < 7; ph++) begin
      case (ph % 3)
        0: set_pinhole($urandom_range(100, 3000), $urandom_range(0, 4095),
                       $urandom_range(0, 4095), rand_coeffs());
        1: begin
          set_pinhole($urandom_range(1, 60), $urandom_range(0, 4095),
                      $urandom_range(0, 4095), rand64());
          write_reg(REG_RAY_D, {4'h0, 28'($urandom), 4'h0, 28'($urandom)});
        end
        default: begin
          write_reg(REG_RAY_A, rand64());
          write_reg(REG_RAY_B, rand64());
          write_reg(REG_RAY_C, rand64());
          write_reg(REG_RAY_D, rand64());
          write_reg(REG_RAY_E, rand64());
          write_reg(REG_FOCAL, rand64());
          write_reg(REG_CENTRE, rand64());
          write_reg(REG_DIST, rand64());
        end
      endcase
      for (int n = 0; n < 250; n++)
        send_pixel(12'($urandom), 12'($urandom));
      drain();
    end
  endtask

  initial begin
    err_count  = 0;
    burst_left = 0;
    for (int i = 0; i < 8; i++) cfg_shadow[i] = 64'd0;
    rst       <= 1'b1;
    start     <= 1'b0;
    pixel     <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_RAY_A;
    cfg_data  <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_state();
    test_pinhole();
    test_axis_and_saturation();
    test_random();

    drain();
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+src
src/fum_pkg.sv
src/fisheye_undistort_map.sv
sim/tb_fisheye_undistort_map.sv
